// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define CRT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must be followed by another one at the next edge.
`define CRT_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- rtl/crt_pkg.sv -----
// ----------------------------------------------------------------------------
// Chunk reassembly table package
// Types, codes and fixed constants shared by the reassembly modules.
// ----------------------------------------------------------------------------
package crt_pkg;

    localparam int HDR_LEN = 17;
    localparam logic [7:0] VERSION = 8'd1;
    localparam logic [7:0] MAGIC0 = 8'h43;
    localparam logic [7:0] MAGIC1 = 8'h4B;
    localparam logic [7:0] MAGIC2 = 8'h44;
    localparam logic [7:0] MAGIC3 = 8'h43;

    localparam logic [1:0] FUNC_BYTE = 2'd0;
    localparam logic [1:0] FUNC_TICK = 2'd1;
    localparam logic [1:0] FUNC_READ = 2'd2;
    localparam logic [1:0] FUNC_NONE = 2'd3;

    localparam logic [1:0] OP_BYTE = 2'd0;
    localparam logic [1:0] OP_END  = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;
    localparam logic [1:0] OP_READ = 2'd3;

    localparam logic [3:0] ST_STORED   = 4'd0;
    localparam logic [3:0] ST_COMPLETE = 4'd1;
    localparam logic [3:0] ST_DUP      = 4'd2;
    localparam logic [3:0] ST_SHORT    = 4'd3;
    localparam logic [3:0] ST_MAGIC    = 4'd4;
    localparam logic [3:0] ST_VERSION  = 4'd5;
    localparam logic [3:0] ST_COUNT    = 4'd6;
    localparam logic [3:0] ST_LEN_RAW  = 4'd7;
    localparam logic [3:0] ST_LEN_MAX  = 4'd8;
    localparam logic [3:0] ST_INDEX    = 4'd9;
    localparam logic [3:0] ST_MISMATCH = 4'd10;
    localparam logic [3:0] ST_BUSY     = 4'd11;
    localparam logic [3:0] ST_BYTE     = 4'd12;
    localparam logic [3:0] ST_EMPTY    = 4'd13;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data;
    } item_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [31:0] id;
        logic [12:0] len;
        logic [7:0]  data;
        logic        last;
        logic [3:0]  ev;
    } result_t;

endpackage

// ----- rtl/crt_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module crt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/crt_front.sv -----
// ----------------------------------------------------------------------------
// Reassembly front end
// Accepts items, classifies them, queues them for the engine, drops FUNC_NONE.
// ----------------------------------------------------------------------------
module crt_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [1:0]     func,
    input  logic [7:0]     data_byte,
    input  logic           end_of_chunk,
    output logic           q_valid,
    input  logic           q_ready,
    output crt_pkg::item_t q_item
);

    crt_pkg::item_t entry_reg [2];
    crt_pkg::item_t entry_next [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] count_reg, count_next;
    crt_pkg::item_t cls;
    logic       push, pop;

    always_comb
    begin
        cls.data = data_byte;
        unique case (func)
            crt_pkg::FUNC_BYTE: cls.op = end_of_chunk ? crt_pkg::OP_END : crt_pkg::OP_BYTE;
            crt_pkg::FUNC_TICK: cls.op = crt_pkg::OP_TICK;
            default:            cls.op = crt_pkg::OP_READ;
        endcase
    end

    assign in_ready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = entry_reg[rptr_reg];
    assign push     = in_valid && in_ready && (func != crt_pkg::FUNC_NONE);
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        entry_next = entry_reg;
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push)
        begin
            entry_next[wptr_reg] = cls;
            wptr_next = ~wptr_reg;
        end
        if (pop)
        begin
            rptr_next = ~rptr_reg;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ----- rtl/crt_engine.sv -----
// ----------------------------------------------------------------------------
// Reassembly engine
// Buffers chunks, validates headers, manages slots, stores payload and reads
// completed messages out.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module crt_engine #(
    parameter int SLOTS       = 8,
    parameter int MAX_CHUNKS  = 16,
    parameter int CHUNK_BYTES = 256
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [31:0]      cfg_wr_data,
    input  logic             q_valid,
    output logic             q_ready,
    input  crt_pkg::item_t   q_item,
    output logic             out_valid,
    input  logic             out_ready,
    output crt_pkg::result_t out_res
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int NCI    = SLOTS * MAX_CHUNKS;
    localparam int CIDX_W = (NCI > 1) ? $clog2(NCI) : 1;
    localparam int NPAY   = NCI * CHUNK_BYTES;
    localparam int PA_W   = $clog2(NPAY);
    localparam int SB_W   = $clog2(CHUNK_BYTES);
    localparam int CL_W   = $clog2(CHUNK_BYTES + 1);
    localparam int RC_W   = $clog2(MAX_CHUNKS + 1);
    localparam int SUM_W  = $clog2(MAX_CHUNKS * CHUNK_BYTES + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_TMO   = 4'd1;
    localparam logic [3:0] S_CHK   = 4'd2;
    localparam logic [3:0] S_ALLOC = 4'd3;
    localparam logic [3:0] S_SLOT  = 4'd4;
    localparam logic [3:0] S_COPY  = 4'd5;
    localparam logic [3:0] S_MARK  = 4'd6;
    localparam logic [3:0] S_SUM   = 4'd7;
    localparam logic [3:0] S_RLEN  = 4'd8;
    localparam logic [3:0] S_RCHK  = 4'd9;
    localparam logic [3:0] S_RBYTE = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [3:0]        state_reg, state_next;
    logic [7:0]        hdr_reg [crt_pkg::HDR_LEN];
    logic [7:0]        hdr_next [crt_pkg::HDR_LEN];
    logic [15:0]       pos_reg, pos_next;
    logic [15:0]       size_reg, size_next;
    logic [31:0]       timeout_reg, timeout_next;
    logic [SLOTS-1:0]  slot_valid_reg, slot_valid_next;
    logic [31:0]       slot_id_reg [SLOTS];
    logic [31:0]       slot_id_next [SLOTS];
    logic [RC_W-1:0]   slot_total_reg [SLOTS];
    logic [RC_W-1:0]   slot_total_next [SLOTS];
    logic [RC_W-1:0]   slot_rcv_reg [SLOTS];
    logic [RC_W-1:0]   slot_rcv_next [SLOTS];
    logic [31:0]       slot_age_reg [SLOTS];
    logic [31:0]       slot_age_next [SLOTS];
    logic [SLOT_W-1:0] order_reg [SLOTS];
    logic [SLOT_W-1:0] order_next [SLOTS];
    logic [CNT_W-1:0]  order_cnt_reg, order_cnt_next;
    logic [NCI-1:0]    present_reg, present_next;
    logic [SLOT_W-1:0] scan_reg, scan_next;
    logic [CNT_W-1:0]  ev_reg, ev_next;
    logic [SLOT_W-1:0] sel_reg, sel_next;
    logic [CL_W-1:0]   copy_k_reg, copy_k_next;
    logic              wr_pend_reg, wr_pend_next;
    logic [SB_W-1:0]   wr_addr_reg, wr_addr_next;
    logic [RC_W-1:0]   sum_i_reg, sum_i_next;
    logic [SUM_W-1:0]  acc_reg, acc_next;
    logic              acc_pend_reg, acc_pend_next;
    logic              rd_pending_reg, rd_pending_next;
    logic [SLOT_W-1:0] rd_slot_reg, rd_slot_next;
    logic [RC_W-1:0]   rd_total_reg, rd_total_next;
    logic [RC_W-1:0]   rd_chunk_reg, rd_chunk_next;
    logic [SUM_W-1:0]  rd_left_reg, rd_left_next;
    logic [31:0]       rd_id_reg, rd_id_next;
    logic [SUM_W-1:0]  rd_len_reg, rd_len_next;
    logic [CL_W-1:0]   rd_ptr_reg, rd_ptr_next;
    crt_pkg::result_t  res_reg, res_next;
    crt_pkg::result_t  out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    logic [31:0]       h_id, h_plen;
    logic [15:0]       h_idx, h_cnt;
    logic [CL_W-1:0]   plen_c;
    logic [RC_W-1:0]   cnt_c;
    logic [CIDX_W-1:0] ci_sel, ci_rd, ci_sum;
    logic [SLOTS-1:0]  match_vec;
    logic              match_any;
    logic [SLOT_W-1:0] match_idx, free_idx;
    logic              drop_en;
    logic [SLOT_W-1:0] drop_s;
    logic              app_en;
    logic [SLOT_W-1:0] app_s;
    logic              shift_on, hit_any;
    logic [SUM_W-1:0]  left_dec;

    logic              stage_we;
    logic [SB_W-1:0]   stage_waddr, stage_raddr;
    logic [7:0]        stage_rdata;
    logic              len_we;
    logic [CIDX_W-1:0] len_raddr;
    logic [CL_W-1:0]   len_rdata;
    logic              pay_we;
    logic [PA_W-1:0]   pay_waddr, pay_raddr;
    logic [7:0]        pay_rdata;

    crt_ram #(.WIDTH(8), .DEPTH(CHUNK_BYTES)) u_stage (
        .clk   (clk),
        .we    (stage_we),
        .waddr (stage_waddr),
        .wdata (q_item.data),
        .raddr (stage_raddr),
        .rdata (stage_rdata)
    );

    crt_ram #(.WIDTH(CL_W), .DEPTH(NCI)) u_len (
        .clk   (clk),
        .we    (len_we),
        .waddr (ci_sel),
        .wdata (plen_c),
        .raddr (len_raddr),
        .rdata (len_rdata)
    );

    crt_ram #(.WIDTH(8), .DEPTH(NPAY)) u_pay (
        .clk   (clk),
        .we    (pay_we),
        .waddr (pay_waddr),
        .wdata (stage_rdata),
        .raddr (pay_raddr),
        .rdata (pay_rdata)
    );

    assign h_id   = {hdr_reg[8], hdr_reg[7], hdr_reg[6], hdr_reg[5]};
    assign h_idx  = {hdr_reg[10], hdr_reg[9]};
    assign h_cnt  = {hdr_reg[12], hdr_reg[11]};
    assign h_plen = {hdr_reg[16], hdr_reg[15], hdr_reg[14], hdr_reg[13]};
    assign plen_c = CL_W'(h_plen);
    assign cnt_c  = RC_W'(h_cnt);
    assign ci_sel = CIDX_W'(int'(sel_reg) * MAX_CHUNKS + int'(h_idx));
    assign ci_rd  = CIDX_W'(int'(rd_slot_reg) * MAX_CHUNKS + int'(rd_chunk_reg));
    assign ci_sum = CIDX_W'(int'(sel_reg) * MAX_CHUNKS + int'(sum_i_reg));
    assign len_raddr = (state_reg == S_SUM) ? ci_sum : ci_rd;
    assign pay_raddr = PA_W'(int'(ci_rd) * CHUNK_BYTES + int'(rd_ptr_reg));
    assign pay_waddr = PA_W'(int'(ci_sel) * CHUNK_BYTES + int'(wr_addr_reg));
    assign pay_we    = wr_pend_reg;
    assign left_dec  = rd_left_reg - SUM_W'(1);

    assign q_ready   = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

    always_comb
    begin
        match_any = 1'b0;
        match_idx = '0;
        free_idx  = '0;
        for (int s = SLOTS - 1; s >= 0; s--)
        begin
            match_vec[s] = slot_valid_reg[s] && (slot_id_reg[s] == h_id);
            if (match_vec[s])
            begin
                match_any = 1'b1;
                match_idx = SLOT_W'(s);
            end
            if (!slot_valid_reg[s])
            begin
                free_idx = SLOT_W'(s);
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        hdr_next        = hdr_reg;
        pos_next        = pos_reg;
        size_next       = size_reg;
        timeout_next    = cfg_wr_en ? cfg_wr_data : timeout_reg;
        slot_valid_next = slot_valid_reg;
        slot_id_next    = slot_id_reg;
        slot_total_next = slot_total_reg;
        slot_rcv_next   = slot_rcv_reg;
        slot_age_next   = slot_age_reg;
        present_next    = present_reg;
        scan_next       = scan_reg;
        ev_next         = ev_reg;
        sel_next        = sel_reg;
        copy_k_next     = copy_k_reg;
        wr_pend_next    = wr_pend_reg;
        wr_addr_next    = wr_addr_reg;
        sum_i_next      = sum_i_reg;
        acc_next        = acc_pend_reg ? acc_reg + SUM_W'(len_rdata) : acc_reg;
        acc_pend_next   = acc_pend_reg;
        rd_pending_next = rd_pending_reg;
        rd_slot_next    = rd_slot_reg;
        rd_total_next   = rd_total_reg;
        rd_chunk_next   = rd_chunk_reg;
        rd_left_next    = rd_left_reg;
        rd_id_next      = rd_id_reg;
        rd_len_next     = rd_len_reg;
        rd_ptr_next     = rd_ptr_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        stage_we        = 1'b0;
        stage_waddr     = SB_W'(pos_reg - 16'(crt_pkg::HDR_LEN));
        stage_raddr     = SB_W'(copy_k_reg);
        len_we          = 1'b0;
        drop_en         = 1'b0;
        drop_s          = '0;
        app_en          = 1'b0;
        app_s           = free_idx;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_item.op)
                        crt_pkg::OP_TICK:
                        begin
                            for (int s = 0; s < SLOTS; s++)
                            begin
                                if (slot_valid_reg[s] && (slot_age_reg[s] != '1))
                                begin
                                    slot_age_next[s] = slot_age_reg[s] + 32'd1;
                                end
                            end
                        end
                        crt_pkg::OP_READ:
                        begin
                            if (rd_pending_reg)
                            begin
                                state_next = S_RLEN;
                            end
                            else
                            begin
                                res_next   = '0;
                                res_next.status = crt_pkg::ST_EMPTY;
                                state_next = S_OUT;
                            end
                        end
                        default:
                        begin
                            if (pos_reg < 16'(crt_pkg::HDR_LEN))
                            begin
                                hdr_next[5'(pos_reg)] = q_item.data;
                            end
                            else if (32'(pos_reg) - crt_pkg::HDR_LEN < CHUNK_BYTES)
                            begin
                                stage_we = 1'b1;
                            end
                            pos_next = (pos_reg == 16'hFFFF) ? pos_reg : pos_reg + 16'd1;
                            if (q_item.op == crt_pkg::OP_END)
                            begin
                                size_next  = pos_next;
                                pos_next   = '0;
                                scan_next  = '0;
                                ev_next    = '0;
                                state_next = S_TMO;
                            end
                        end
                    endcase
                end
            end
            S_TMO:
            begin
                if (slot_valid_reg[scan_reg] && (slot_age_reg[scan_reg] > timeout_reg))
                begin
                    slot_valid_next[scan_reg] = 1'b0;
                    drop_en = 1'b1;
                    drop_s  = scan_reg;
                    ev_next = ev_reg + CNT_W'(1);
                end
                scan_next = scan_reg + SLOT_W'(1);
                if (scan_reg == SLOT_W'(SLOTS - 1))
                begin
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                res_next    = '0;
                res_next.id = h_id;
                res_next.ev = 4'(ev_reg);
                state_next  = S_OUT;
                if (size_reg < 16'(crt_pkg::HDR_LEN))
                begin
                    res_next.status = crt_pkg::ST_SHORT;
                    res_next.id     = '0;
                end
                else if (rd_pending_reg)
                    res_next.status = crt_pkg::ST_BUSY;
                else if (hdr_reg[0] != crt_pkg::MAGIC0 || hdr_reg[1] != crt_pkg::MAGIC1 ||
                         hdr_reg[2] != crt_pkg::MAGIC2 || hdr_reg[3] != crt_pkg::MAGIC3)
                    res_next.status = crt_pkg::ST_MAGIC;
                else if (hdr_reg[4] != crt_pkg::VERSION)
                    res_next.status = crt_pkg::ST_VERSION;
                else if (h_cnt == 16'd0 || 32'(h_cnt) > MAX_CHUNKS)
                    res_next.status = crt_pkg::ST_COUNT;
                else if (33'(crt_pkg::HDR_LEN) + 33'(h_plen) > 33'(size_reg))
                    res_next.status = crt_pkg::ST_LEN_RAW;
                else if (h_plen > CHUNK_BYTES)
                    res_next.status = crt_pkg::ST_LEN_MAX;
                else if (h_idx >= h_cnt)
                    res_next.status = crt_pkg::ST_INDEX;
                else if (match_any)
                begin
                    sel_next   = match_idx;
                    state_next = S_SLOT;
                end
                else
                begin
                    if (&slot_valid_reg)
                    begin
                        slot_valid_next[order_reg[0]] = 1'b0;
                        drop_en = 1'b1;
                        drop_s  = order_reg[0];
                        ev_next = ev_reg + CNT_W'(1);
                    end
                    state_next = S_ALLOC;
                end
            end
            S_ALLOC:
            begin
                slot_valid_next[free_idx] = 1'b1;
                slot_id_next[free_idx]    = h_id;
                slot_total_next[free_idx] = cnt_c;
                slot_rcv_next[free_idx]   = '0;
                slot_age_next[free_idx]   = '0;
                for (int i = 0; i < MAX_CHUNKS; i++)
                begin
                    present_next[CIDX_W'(int'(free_idx) * MAX_CHUNKS + i)] = 1'b0;
                end
                app_en     = 1'b1;
                sel_next   = free_idx;
                state_next = S_SLOT;
            end
            S_SLOT:
            begin
                res_next    = '0;
                res_next.id = h_id;
                res_next.ev = 4'(ev_reg);
                if (16'(slot_total_reg[sel_reg]) != h_cnt)
                begin
                    res_next.status = crt_pkg::ST_MISMATCH;
                    state_next = S_OUT;
                end
                else if (present_reg[ci_sel])
                begin
                    res_next.status = crt_pkg::ST_DUP;
                    state_next = S_OUT;
                end
                else
                begin
                    copy_k_next  = '0;
                    wr_pend_next = 1'b0;
                    state_next   = S_COPY;
                end
            end
            S_COPY:
            begin
                if (copy_k_reg < plen_c)
                begin
                    wr_pend_next = 1'b1;
                    wr_addr_next = SB_W'(copy_k_reg);
                    copy_k_next  = copy_k_reg + CL_W'(1);
                end
                else
                begin
                    wr_pend_next = 1'b0;
                    if (!wr_pend_reg)
                    begin
                        state_next = S_MARK;
                    end
                end
            end
            S_MARK:
            begin
                present_next[ci_sel]   = 1'b1;
                len_we                 = 1'b1;
                slot_rcv_next[sel_reg] = slot_rcv_reg[sel_reg] + RC_W'(1);
                if (slot_rcv_next[sel_reg] < slot_total_reg[sel_reg])
                begin
                    res_next.status = crt_pkg::ST_STORED;
                    state_next = S_OUT;
                end
                else
                begin
                    sum_i_next    = '0;
                    acc_next      = '0;
                    acc_pend_next = 1'b0;
                    state_next    = S_SUM;
                end
            end
            S_SUM:
            begin
                if (sum_i_reg < cnt_c)
                begin
                    acc_pend_next = 1'b1;
                    sum_i_next    = sum_i_reg + RC_W'(1);
                end
                else
                begin
                    acc_pend_next = 1'b0;
                    if (!acc_pend_reg)
                    begin
                        rd_len_next     = acc_reg;
                        rd_left_next    = acc_reg;
                        rd_slot_next    = sel_reg;
                        rd_total_next   = cnt_c;
                        rd_chunk_next   = '0;
                        rd_ptr_next     = '0;
                        rd_id_next      = h_id;
                        rd_pending_next = (acc_reg != '0);
                        slot_valid_next[sel_reg] = 1'b0;
                        drop_en         = 1'b1;
                        drop_s          = sel_reg;
                        res_next.status = crt_pkg::ST_COMPLETE;
                        res_next.len    = 13'(acc_reg);
                        state_next      = S_OUT;
                    end
                end
            end
            S_RLEN:
            begin
                state_next = S_RCHK;
            end
            S_RCHK:
            begin
                if (rd_chunk_reg < rd_total_reg && rd_ptr_reg >= len_rdata)
                begin
                    rd_chunk_next = rd_chunk_reg + RC_W'(1);
                    rd_ptr_next   = '0;
                    state_next    = S_RLEN;
                end
                else if (rd_chunk_reg >= rd_total_reg)
                begin
                    rd_pending_next = 1'b0;
                    res_next        = '0;
                    res_next.status = crt_pkg::ST_EMPTY;
                    state_next      = S_OUT;
                end
                else
                begin
                    state_next = S_RBYTE;
                end
            end
            S_RBYTE:
            begin
                rd_ptr_next     = rd_ptr_reg + CL_W'(1);
                rd_left_next    = left_dec;
                rd_pending_next = (left_dec != '0);
                res_next.status = crt_pkg::ST_BYTE;
                res_next.id     = rd_id_reg;
                res_next.len    = 13'(rd_len_reg);
                res_next.data   = pay_rdata;
                res_next.last   = (left_dec == '0);
                res_next.ev     = '0;
                state_next      = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Allocation order queue: removal closes the gap, allocation appends.
    always_comb
    begin
        order_next     = order_reg;
        order_cnt_next = order_cnt_reg;
        shift_on       = 1'b0;
        hit_any        = 1'b0;
        for (int j = 0; j < SLOTS; j++)
        begin
            if (drop_en && (CNT_W'(j) < order_cnt_reg) && (order_reg[j] == drop_s))
            begin
                shift_on = 1'b1;
                hit_any  = 1'b1;
            end
            if (shift_on && (j < SLOTS - 1))
            begin
                order_next[j] = order_reg[(j + 1) % SLOTS];
            end
        end
        if (hit_any)
        begin
            order_cnt_next = order_cnt_reg - CNT_W'(1);
        end
        if (app_en && (order_cnt_reg < CNT_W'(SLOTS)))
        begin
            order_next[SLOT_W'(order_cnt_reg)] = app_s;
            order_cnt_next = order_cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pos_reg        <= '0;
            timeout_reg    <= 32'd1000;
            slot_valid_reg <= '0;
            order_cnt_reg  <= '0;
            present_reg    <= '0;
            wr_pend_reg    <= 1'b0;
            acc_pend_reg   <= 1'b0;
            rd_pending_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            timeout_reg    <= timeout_next;
            slot_valid_reg <= slot_valid_next;
            order_cnt_reg  <= order_cnt_next;
            present_reg    <= present_next;
            wr_pend_reg    <= wr_pend_next;
            acc_pend_reg   <= acc_pend_next;
            rd_pending_reg <= rd_pending_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hdr_reg        <= hdr_next;
        size_reg       <= size_next;
        slot_id_reg    <= slot_id_next;
        slot_total_reg <= slot_total_next;
        slot_rcv_reg   <= slot_rcv_next;
        slot_age_reg   <= slot_age_next;
        order_reg      <= order_next;
        scan_reg       <= scan_next;
        ev_reg         <= ev_next;
        sel_reg        <= sel_next;
        copy_k_reg     <= copy_k_next;
        wr_addr_reg    <= wr_addr_next;
        sum_i_reg      <= sum_i_next;
        acc_reg        <= acc_next;
        rd_slot_reg    <= rd_slot_next;
        rd_total_reg   <= rd_total_next;
        rd_chunk_reg   <= rd_chunk_next;
        rd_left_reg    <= rd_left_next;
        rd_id_reg      <= rd_id_next;
        rd_len_reg     <= rd_len_next;
        rd_ptr_reg     <= rd_ptr_next;
        res_reg        <= res_next;
        out_reg        <= out_next;
    end

    `CRT_ASSERT(a_left_nonzero, !rd_pending_reg || (rd_left_reg != '0), "pending readout has no bytes left")
    `CRT_ASSERT(a_order_count, 32'(order_cnt_reg) == $countones(slot_valid_reg), "allocation order out of step with valid slots")
    `CRT_ASSERT_NEXT(a_out_load, (state_reg == S_OUT) && !out_valid_reg, out_valid_reg, "result not loaded into output register")
    `CRT_ASSERT_NEXT(a_copy_done, (state_reg == S_COPY) && !wr_pend_reg && (copy_k_reg >= plen_c), state_reg == S_MARK, "payload copy did not finish")

endmodule

// ----- rtl/chunk_reassembly_table.sv -----
// ----------------------------------------------------------------------------
// Chunk reassembly table
// Reassembles messages from headered chunks and reads them out byte by byte.
// ----------------------------------------------------------------------------
//  Channel   Handshake               Payload
//  input     in_valid / in_ready     func, data_byte, end_of_chunk
//  output    out_valid / out_ready   status, msg_id, message_length,
//                                    out_byte, last_of_message, evicted_slots
//  config    cfg_wr_en               cfg_wr_data (timeout in ticks)
//
//  The engine takes chunk bytes and ticks in its idle state; a two-item queue
//  in front keeps accepting while the engine works.
//  At a chunk end the timeout scan walks the slots, and the payload copy and
//  length sum use one RAM port each. A readout byte passes S_RLEN, S_RCHK,
//  S_RBYTE and S_OUT, repeating S_RLEN and S_RCHK at each chunk boundary.
//  Reset is asynchronous and active low; no clearing pass is needed.
//  A stalled output holds the engine in its final state until taken.
// ----------------------------------------------------------------------------
module chunk_reassembly_table #(
    parameter int SLOTS       = 8,
    parameter int MAX_CHUNKS  = 16,
    parameter int CHUNK_BYTES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [7:0]  data_byte,
    input  logic        end_of_chunk,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  status,
    output logic [31:0] msg_id,
    output logic [12:0] message_length,
    output logic [7:0]  out_byte,
    output logic        last_of_message,
    output logic [3:0]  evicted_slots
);

    logic             q_valid;
    logic             q_ready;
    crt_pkg::item_t   q_item;
    crt_pkg::result_t res;

    crt_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .data_byte    (data_byte),
        .end_of_chunk (end_of_chunk),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_item       (q_item)
    );

    crt_engine #(
        .SLOTS       (SLOTS),
        .MAX_CHUNKS  (MAX_CHUNKS),
        .CHUNK_BYTES (CHUNK_BYTES)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_item      (q_item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_res     (res)
    );

    assign status          = res.status;
    assign msg_id          = res.id;
    assign message_length  = res.len;
    assign out_byte        = res.data;
    assign last_of_message = res.last;
    assign evicted_slots   = res.ev;

endmodule

// ----- tb/sv/chunk_reassembly_table_tb.sv -----
// ----------------------------------------------------------------------------
// Chunk reassembly table testbench
// Drives headered chunks, ticks and readout requests through the valid/ready
// input channel, predicts every result in step with each accepted item, and
// checks the results in order, under random gaps on both channels and under
// several timeout settings.
// ----------------------------------------------------------------------------
module chunk_reassembly_table_tb;

    localparam int NSLOT = 8;
    localparam int NCHK = 16;
    localparam int CBYTES = 256;
    localparam int QUIET_CYCLES = 500;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct {
        bit         is_cfg;
        bit [1:0]   f;
        bit [7:0]   d;
        bit         e;
        bit [31:0]  cv;
    } stim_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  func;
    logic [7:0]  data_byte;
    logic        end_of_chunk;
    logic        out_valid;
    logic        out_ready;
    logic [3:0]  status;
    logic [31:0] msg_id;
    logic [12:0] message_length;
    logic [7:0]  out_byte;
    logic        last_of_message;
    logic [3:0]  evicted_slots;

    stim_t            stim_q[$];
    crt_pkg::result_t expected_q[$];
    int      mismatches = 0;
    longint  cycles = 0;
    bit      accepted = 0;
    bit      burst = 0;
    int      in_gap = 0;
    int      out_gap = 0;
    int      quiet = 0;

    // Predicted block state.
    bit [31:0]   timeout_ticks;
    bit [7:0]    hdr[crt_pkg::HDR_LEN];
    int unsigned raw_count;
    bit [7:0]    stage[CBYTES];
    bit          slot_busy[NSLOT];
    bit [31:0]   slot_id[NSLOT];
    int unsigned slot_total[NSLOT];
    int unsigned slot_got[NSLOT];
    bit [31:0]   slot_age[NSLOT];
    int          alloc_q[$];
    bit          chunk_here[NSLOT*NCHK];
    int unsigned chunk_len[NSLOT*NCHK];
    bit [7:0]    store[NSLOT*NCHK*CBYTES];
    bit          rd_pending;
    int unsigned rd_slot, rd_total, rd_chunk, rd_left, rd_len, rd_ptr;
    bit [31:0]   rd_id;

    chunk_reassembly_table dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .func(func), .data_byte(data_byte), .end_of_chunk(end_of_chunk),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .msg_id(msg_id), .message_length(message_length),
        .out_byte(out_byte), .last_of_message(last_of_message),
        .evicted_slots(evicted_slots)
    );

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    function automatic void free_slot(int s);
        slot_busy[s] = 0;
        foreach (alloc_q[i])
            if (alloc_q[i] == s)
            begin
                alloc_q.delete(i);
                break;
            end
    endfunction

    function automatic bit [3:0] close_chunk(ref int unsigned ev, ref bit [31:0] id);
        int s;
        int used;
        int unsigned idx, cnt, base;
        bit [31:0] plen;
        for (s = 0; s < NSLOT; s++)
            if (slot_busy[s] && slot_age[s] > timeout_ticks)
            begin
                free_slot(s);
                ev++;
            end
        if (raw_count < crt_pkg::HDR_LEN)
        begin
            id = 0;
            return crt_pkg::ST_SHORT;
        end
        id = {hdr[8], hdr[7], hdr[6], hdr[5]};
        if (rd_pending) return crt_pkg::ST_BUSY;
        if (hdr[0] != crt_pkg::MAGIC0 || hdr[1] != crt_pkg::MAGIC1 ||
            hdr[2] != crt_pkg::MAGIC2 || hdr[3] != crt_pkg::MAGIC3)
            return crt_pkg::ST_MAGIC;
        if (hdr[4] != crt_pkg::VERSION) return crt_pkg::ST_VERSION;
        idx = 32'({hdr[10], hdr[9]});
        cnt = 32'({hdr[12], hdr[11]});
        plen = {hdr[16], hdr[15], hdr[14], hdr[13]};
        if (cnt < 1 || cnt > NCHK) return crt_pkg::ST_COUNT;
        if (longint'(crt_pkg::HDR_LEN) + longint'(plen) > longint'(raw_count))
            return crt_pkg::ST_LEN_RAW;
        if (plen > CBYTES) return crt_pkg::ST_LEN_MAX;
        if (idx >= cnt) return crt_pkg::ST_INDEX;
        for (s = 0; s < NSLOT; s++)
            if (slot_busy[s] && slot_id[s] == id) break;
        if (s == NSLOT)
        begin
            used = 0;
            foreach (slot_busy[i]) used += slot_busy[i];
            if (used >= NSLOT && alloc_q.size() > 0)
            begin
                free_slot(alloc_q[0]);
                ev++;
            end
            for (s = 0; s < NSLOT; s++)
                if (!slot_busy[s]) break;
            slot_busy[s] = 1;
            slot_id[s] = id;
            slot_total[s] = cnt;
            slot_got[s] = 0;
            slot_age[s] = 0;
            for (int i = 0; i < NCHK; i++) chunk_here[s*NCHK+i] = 0;
            alloc_q.insert(alloc_q.size(), s);
        end
        if (slot_total[s] != cnt) return crt_pkg::ST_MISMATCH;
        base = s*NCHK + idx;
        if (chunk_here[base]) return crt_pkg::ST_DUP;
        for (int i = 0; i < plen; i++) store[base*CBYTES+i] = stage[i];
        chunk_here[base] = 1;
        chunk_len[base] = plen;
        slot_got[s]++;
        if (slot_got[s] < slot_total[s]) return crt_pkg::ST_STORED;
        rd_len = 0;
        for (int i = 0; i < cnt; i++) rd_len += chunk_len[s*NCHK+i];
        rd_slot = s;
        rd_total = cnt;
        rd_chunk = 0;
        rd_ptr = 0;
        rd_left = rd_len;
        rd_id = id;
        rd_pending = rd_len > 0;
        free_slot(s);
        return crt_pkg::ST_COMPLETE;
    endfunction

    function automatic void predict_item(bit [1:0] f, bit [7:0] d, bit e);
        crt_pkg::result_t r;
        int unsigned ev, ci;
        bit [31:0] id;
        r = '0;
        ev = 0;
        id = 0;
        if (f == crt_pkg::FUNC_BYTE)
        begin
            if (raw_count < crt_pkg::HDR_LEN) hdr[raw_count] = d;
            else if (raw_count - crt_pkg::HDR_LEN < CBYTES)
                stage[raw_count-crt_pkg::HDR_LEN] = d;
            if (raw_count < 65535) raw_count++;
            if (!e) return;
            r.status = close_chunk(ev, id);
            raw_count = 0;
            r.id = id;
            r.len = (r.status == crt_pkg::ST_COMPLETE) ? rd_len[12:0] : 13'd0;
            r.ev = ev[3:0];
            expected_q.insert(expected_q.size(), r);
        end
        else if (f == crt_pkg::FUNC_TICK)
        begin
            foreach (slot_busy[s])
                if (slot_busy[s] && slot_age[s] != 32'hFFFF_FFFF) slot_age[s]++;
        end
        else if (f == crt_pkg::FUNC_READ)
        begin
            r.status = crt_pkg::ST_EMPTY;
            if (rd_pending)
            begin
                while (rd_chunk < rd_total && rd_chunk < NCHK &&
                       rd_ptr >= chunk_len[rd_slot*NCHK+rd_chunk])
                begin
                    rd_chunk++;
                    rd_ptr = 0;
                end
                if (rd_chunk >= rd_total || rd_chunk >= NCHK)
                    rd_pending = 0;
                else
                begin
                    ci = rd_slot*NCHK + rd_chunk;
                    r.data = store[(ci*CBYTES + rd_ptr) % (NSLOT*NCHK*CBYTES)];
                    rd_ptr++;
                    if (rd_left > 0) rd_left--;
                    if (rd_left == 0) rd_pending = 0;
                    r.status = crt_pkg::ST_BYTE;
                    r.id = rd_id;
                    r.len = rd_len[12:0];
                    r.last = (rd_left == 0);
                end
            end
            expected_q.insert(expected_q.size(), r);
        end
    endfunction

    task automatic add_item(bit [1:0] f, bit [7:0] d, bit e);
        stim_q.insert(stim_q.size(), '{0, f, d, e, 0});
    endtask

    task automatic add_cfg(bit [31:0] v);
        stim_q.insert(stim_q.size(), '{1, crt_pkg::FUNC_NONE, 0, 0, v});
    endtask

    task automatic add_raw(int n);
        for (int i = 0; i < n; i++)
            add_item(crt_pkg::FUNC_BYTE, 8'($urandom_range(0, 255)), i == n-1);
    endtask

    task automatic add_chunk(bit [31:0] id, bit [15:0] idx, bit [15:0] cnt, bit [31:0] plen,
                             int nbytes, bit [7:0] ver = crt_pkg::VERSION,
                             bit [7:0] m0 = crt_pkg::MAGIC0);
        bit [7:0] h[crt_pkg::HDR_LEN];
        h = '{m0, crt_pkg::MAGIC1, crt_pkg::MAGIC2, crt_pkg::MAGIC3, ver,
              id[7:0], id[15:8], id[23:16], id[31:24],
              idx[7:0], idx[15:8], cnt[7:0], cnt[15:8],
              plen[7:0], plen[15:8], plen[23:16], plen[31:24]};
        for (int i = 0; i < crt_pkg::HDR_LEN; i++)
            add_item(crt_pkg::FUNC_BYTE, h[i], nbytes == 0 && i == crt_pkg::HDR_LEN-1);
        for (int i = 0; i < nbytes; i++)
            add_item(crt_pkg::FUNC_BYTE, 8'($urandom_range(0, 255)), i == nbytes-1);
    endtask

    task automatic add_reads(int n);
        repeat (n)
            add_item(crt_pkg::FUNC_READ, 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)));
    endtask

    task automatic add_ticks(int n);
        repeat (n)
            add_item(crt_pkg::FUNC_TICK, 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)));
    endtask

    task automatic add_message(bit [31:0] id, int cnt, int maxlen, bit drop_one);
        int order[$];
        int lens[NCHK];
        int total;
        int skip;
        total = 0;
        skip = drop_one ? $urandom_range(0, cnt-1) : -1;
        for (int i = 0; i < cnt; i++)
        begin
            order.insert(order.size(), i);
            lens[i] = ($urandom_range(0, 19) == 0) ? CBYTES : $urandom_range(0, maxlen);
            total += lens[i];
        end
        order.shuffle();
        foreach (order[k])
        begin
            if (order[k] == skip) continue;
            add_chunk(id, 16'(order[k]), 16'(cnt), lens[order[k]],
                      lens[order[k]] + ($urandom_range(0, 3) == 0 ? $urandom_range(1, 4) : 0));
            if ($urandom_range(0, 5) == 0) add_ticks($urandom_range(1, 3));
            if ($urandom_range(0, 9) == 0 && k + 1 < cnt)
                add_chunk(id, 16'(order[k]), 16'(cnt), lens[order[k]], lens[order[k]]);
        end
        if (!drop_one) add_reads(total + $urandom_range(0, 1));
    endtask

    task automatic add_bad_chunk();
        bit [31:0] id;
        id = $urandom_range(0, 15);
        case ($urandom_range(0, 7))
            0: add_raw($urandom_range(1, 16));
            1: add_chunk(id, 0, 1, 2, 2, crt_pkg::VERSION, 8'($urandom_range(0, 255)));
            2: add_chunk(id, 0, 1, 2, 2, 8'($urandom_range(2, 255)));
            3: add_chunk(id, 0, $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(17, 65535)),
                         1, 1);
            4: add_chunk(id, 0, 1, $urandom_range(3, 40), 2);
            5: add_chunk(id, 0, 1, $urandom, 4);
            6: add_chunk(id, 16'($urandom_range(2, 65535)), 2, 1, 1);
            default: add_chunk(id, 16'($urandom_range(0, 3)), 16'($urandom_range(1, 16)), 3, 3);
        endcase
    endtask

    task automatic add_random_phase(int n_items);
        int target;
        int r;
        target = stim_q.size() + n_items;
        while (stim_q.size() < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
                add_message($urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom,
                            $urandom_range(1, 4), 12, 0);
            else if (r < 75)
                add_message($urandom_range(0, 15), $urandom_range(2, 4), 8, 1);
            else if (r < 85)
                add_bad_chunk();
            else if (r < 90)
                add_ticks($urandom_range(1, 10));
            else if (r < 95)
            begin
                add_item(crt_pkg::FUNC_NONE, 8'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)));
                add_reads(1);
            end
            else
                add_chunk($urandom_range(0, 15), 16'($urandom_range(0, 3)),
                          16'($urandom_range(1, 16)), 3, 3);
        end
    endtask

    initial
    begin
        timeout_ticks = 1000;
        raw_count = 0;
        rd_pending = 0;
        foreach (slot_busy[i]) slot_busy[i] = 0;
        foreach (chunk_here[i]) chunk_here[i] = 0;

        // Directed items: every operation, each header check and the corner cases.
        add_raw(5);
        add_raw(16);
        add_chunk(32'hFFFF_FFFF, 0, 1, 3, 3, crt_pkg::VERSION, 8'h00);
        add_chunk(32'h0, 0, 1, 3, 3, 8'hFF);
        add_chunk(7, 0, 0, 0, 0);
        add_chunk(7, 0, 17, 0, 0);
        add_chunk(7, 0, 1, 10, 5);
        add_chunk(7, 0, 1, 257, 258);
        add_chunk(7, 3, 3, 0, 0);
        add_item(crt_pkg::FUNC_NONE, 8'hFF, 1);
        add_reads(1);
        add_chunk(9, 0, 1, 0, 0);
        add_reads(1);
        add_chunk(32'hFFFF_FFFF, 1, 2, 4, 10);
        add_chunk(32'hFFFF_FFFF, 1, 2, 4, 4);
        add_chunk(32'hFFFF_FFFF, 0, 3, 1, 1);
        add_ticks(2);
        add_chunk(32'hFFFF_FFFF, 0, 2, 256, 256);
        add_chunk(5, 0, 1, 1, 1);
        add_reads(262);
        for (int i = 0; i < 9; i++) add_chunk(100 + i, 0, 2, 1, 1);

        add_cfg(32'hFFFF_FFFF);
        add_random_phase(150);
        add_cfg(0);
        for (int i = 0; i < 3; i++) add_chunk(200 + i, 0, 2, 1, 1);
        add_ticks(1);
        add_random_phase(100);
        add_cfg(5);
        add_random_phase(120);
        add_cfg(1000);
        add_random_phase(60);
    end

    initial
    begin
        rst_n = 0;
        cfg_wr_en = 0;
        cfg_wr_data = 0;
        in_valid = 0;
        func = crt_pkg::FUNC_NONE;
        data_byte = 0;
        end_of_chunk = 0;
        out_ready = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        if (rst_n && in_valid && in_ready)
        begin
            predict_item(func, data_byte, end_of_chunk);
            accepted = 1;
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: status %0d id %h", status, msg_id);
            end
            else
            begin
                crt_pkg::result_t x;
                x = expected_q.pop_front();
                if (status !== x.status || msg_id !== x.id || message_length !== x.len ||
                    out_byte !== x.data || last_of_message !== x.last ||
                    evicted_slots !== x.ev)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("Mismatch: expected st %0d id %h len %0d byte %h last %b ev %0d",
                                 x.status, x.id, x.len, x.data, x.last, x.ev);
                        $display("          got st %0d id %h len %0d byte %h last %b ev %0d",
                                 status, msg_id, message_length, out_byte, last_of_message,
                                 evicted_slots);
                    end
                end
            end
        end
    end

    always @(negedge clk)
    begin
        bit cfg_now;
        cfg_now = 0;
        if (rst_n)
        begin
            if ($urandom_range(0, 299) == 0) burst = !burst;
            if (!(in_valid && !accepted))
            begin
                accepted = 0;
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 0;
                end
                else if (stim_q.size() == 0)
                    in_valid <= 0;
                else if (stim_q[0].is_cfg)
                begin
                    in_valid <= 0;
                    if (expected_q.size() != 0)
                        quiet = 0;
                    else if (++quiet >= QUIET_CYCLES)
                    begin
                        cfg_now = 1;
                        cfg_wr_data <= stim_q[0].cv;
                        timeout_ticks = stim_q[0].cv;
                        void'(stim_q.pop_front());
                        quiet = 0;
                    end
                end
                else
                begin
                    in_valid <= 1;
                    func <= stim_q[0].f;
                    data_byte <= stim_q[0].d;
                    end_of_chunk <= stim_q[0].e;
                    void'(stim_q.pop_front());
                    in_gap = pick_gap();
                end
            end
            if (out_gap > 0)
            begin
                out_gap--;
                out_ready <= 0;
            end
            else
            begin
                out_ready <= 1;
                out_gap = pick_gap();
            end
        end
        cfg_wr_en <= cfg_now;
    end

    initial
    begin
        @(posedge rst_n);
        do @(posedge clk); while (stim_q.size() != 0 || in_valid);
        while (expected_q.size() != 0) @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/crt_pkg.sv
rtl/crt_ram.sv
rtl/crt_front.sv
rtl/crt_engine.sv
rtl/chunk_reassembly_table.sv
tb/sv/chunk_reassembly_table_tb.sv
